// File: hdl/wlrp_pkg.sv
package wlrp_pkg;

    // Policy modes reported on the result channel.
    localparam logic [2:0] MODE_STARTING   = 3'd0;
    localparam logic [2:0] MODE_CONNECTING = 3'd1;
    localparam logic [2:0] MODE_ONLINE     = 3'd2;
    localparam logic [2:0] MODE_LOST       = 3'd3;
    localparam logic [2:0] MODE_AP         = 3'd4;

    // Action codes.
    localparam logic [2:0] ACT_NONE     = 3'd0;
    localparam logic [2:0] ACT_START_AP = 3'd1;
    localparam logic [2:0] ACT_STOP_AP  = 3'd2;
    localparam logic [2:0] ACT_FAST     = 3'd3;
    localparam logic [2:0] ACT_SCAN     = 3'd4;
    localparam logic [2:0] ACT_FORGET   = 3'd5;
    localparam logic [2:0] ACT_RESTART  = 3'd6;

    // Configuration register indexes.
    localparam logic [2:0] REG_START_DELAY   = 3'd0;
    localparam logic [2:0] REG_ATT_TIMEOUT   = 3'd1;
    localparam logic [2:0] REG_PROBE_PERIOD  = 3'd2;
    localparam logic [2:0] REG_LOST_FALLBACK = 3'd3;
    localparam logic [2:0] REG_ROUND_PAUSE   = 3'd4;
    localparam logic [2:0] REG_ATT_PER_ROUND = 3'd5;
    localparam logic [2:0] REG_FAST_FAIL_LIM = 3'd6;
    localparam logic [2:0] REG_RESTART_EVERY = 3'd7;

    // Width of the failed round counter, which sets the remainder unit length.
    localparam int ROUND_W = 16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_step;
        logic exec;
    } wlrp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
    } wlrp_sts_t;

endpackage

// File: hdl/wlrp_ctrl.sv
module wlrp_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  wlrp_pkg::wlrp_sts_t sts,
    output wlrp_pkg::wlrp_cmd_t cmd
);
    import wlrp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    // Sequence one tick: latch, remainder steps, then update once the output is free.
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (sts.div_done) begin
                    state_next = S_EXEC;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    cmd.exec     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: hdl/wlrp_dpath.sv
module wlrp_dpath #(
    parameter logic [31:0] AP_STOP_GRACE_TIME = 32'd60000,
    parameter logic [31:0] AP_RETRY_TIME      = 32'd5000,
    parameter logic [31:0] AP_MANUAL_TIME     = 32'd300000,
    parameter logic [31:0] PORTAL_IDLE_TIME   = 32'd60000
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_addr,
    input  logic [31:0]        cfg_wdata,
    input  logic [31:0]        s_time_ms,
    input  logic               s_link_up,
    input  logic               s_has_credentials,
    input  logic               s_has_fast_pair,
    input  logic               s_ap_active,
    input  logic [7:0]         s_ap_client_count,
    input  logic               s_manual_ap_request,
    input  logic               s_new_network_request,
    input  logic               s_portal_hit,
    input  wlrp_pkg::wlrp_cmd_t cmd,
    output wlrp_pkg::wlrp_sts_t sts,
    output logic [2:0]         m_action,
    output logic [2:0]         m_mode,
    output logic [15:0]        m_failed_attempt_total
);
    import wlrp_pkg::*;

    localparam int CNT_W = $clog2(ROUND_W + 1);

    // Configuration registers.
    logic [31:0] start_delay_reg, att_timeout_reg, probe_period_reg;
    logic [31:0] lost_fallback_reg, round_pause_reg;
    logic [7:0]  att_per_round_reg, fast_fail_lim_reg, restart_every_reg;

    // Latched tick.
    logic [31:0] now_reg;
    logic        link_reg, creds_reg, fastp_reg, apup_reg, man_reg, newnet_reg, hit_reg;
    logic [7:0]  clients_reg;

    // Policy state.
    logic [2:0]  mode_reg;
    logic        started_reg, attempting_reg, att_fast_reg, fast_dis_reg, forget_reg;
    logic        ever_on_reg, ap_manual_reg, busy_valid_reg;
    logic [7:0]  prev_clients_reg, fast_fail_cnt_reg, attempt_idx_reg;
    logic [15:0] round_cnt_reg, fail_cnt_reg;
    logic [31:0] tm_online_reg, tm_lost_reg, tm_attempt_reg, tm_wait_reg;
    logic [31:0] tm_apreq_reg, tm_busy_reg, cur_wait_reg;

    // Remainder unit state.
    logic [ROUND_W-1:0] div_num_reg;
    logic [8:0]         div_rem_reg;
    logic [CNT_W-1:0]   div_cnt_reg;
    logic [8:0]         rem_shift;

    // Next values.
    logic [2:0]  mode_next, act_next;
    logic        started_next, attempting_next, att_fast_next, fast_dis_next, forget_next;
    logic        ever_on_next, ap_manual_next, busy_valid_next;
    logic [7:0]  fast_fail_cnt_next, attempt_idx_next, att_inc, per_round, fail_lim;
    logic [15:0] round_cnt_next, fail_cnt_next;
    logic [31:0] tm_online_next, tm_lost_next, tm_attempt_next, tm_wait_next;
    logic [31:0] tm_apreq_next, tm_busy_next, cur_wait_next;
    logic        do_start, fast_ok, do_enter, enter_manual, fast_sel, keep_manual;
    logic        mod_zero;

    function automatic logic elapsed(input logic [31:0] now, input logic [31:0] since,
                                     input logic [31:0] period);
        logic [31:0] diff;
        diff = now - since;
        return diff >= period;
    endfunction

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_delay_reg   <= 32'd3000;
            att_timeout_reg   <= 32'd15000;
            probe_period_reg  <= 32'd60000;
            lost_fallback_reg <= 32'd120000;
            round_pause_reg   <= 32'd30000;
            att_per_round_reg <= 8'd2;
            fast_fail_lim_reg <= 8'd3;
            restart_every_reg <= 8'd3;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_START_DELAY:   start_delay_reg   <= cfg_wdata;
                REG_ATT_TIMEOUT:   att_timeout_reg   <= cfg_wdata;
                REG_PROBE_PERIOD:  probe_period_reg  <= cfg_wdata;
                REG_LOST_FALLBACK: lost_fallback_reg <= cfg_wdata;
                REG_ROUND_PAUSE:   round_pause_reg   <= cfg_wdata;
                REG_ATT_PER_ROUND: att_per_round_reg <= cfg_wdata[7:0];
                REG_FAST_FAIL_LIM: fast_fail_lim_reg <= cfg_wdata[7:0];
                REG_RESTART_EVERY: restart_every_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Input transaction capture.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            now_reg     <= s_time_ms;
            link_reg    <= s_link_up;
            creds_reg   <= s_has_credentials;
            fastp_reg   <= s_has_fast_pair;
            apup_reg    <= s_ap_active;
            clients_reg <= s_ap_client_count;
            man_reg     <= s_manual_ap_request;
            newnet_reg  <= s_new_network_request;
            hit_reg     <= s_portal_hit;
        end
    end

    // Restoring remainder of the next round count by the restart interval, one bit a cycle.
    assign rem_shift    = {div_rem_reg[7:0], div_num_reg[ROUND_W-1]};
    assign sts.div_done = (div_cnt_reg == '0);
    assign mod_zero     = (div_rem_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (cmd.load) begin
            div_num_reg <= round_cnt_reg + 16'd1;
            div_rem_reg <= '0;
            div_cnt_reg <= CNT_W'(ROUND_W);
        end else if (cmd.div_step) begin
            div_num_reg <= {div_num_reg[ROUND_W-2:0], 1'b0};
            div_cnt_reg <= div_cnt_reg - CNT_W'(1);
            if (rem_shift >= {1'b0, restart_every_reg}) begin
                div_rem_reg <= rem_shift - {1'b0, restart_every_reg};
            end else begin
                div_rem_reg <= rem_shift;
            end
        end
    end

    // Policy decision for one tick.
    always_comb begin
        mode_next          = mode_reg;
        act_next           = ACT_NONE;
        started_next       = started_reg;
        attempting_next    = attempting_reg;
        att_fast_next      = att_fast_reg;
        fast_dis_next      = fast_dis_reg;
        forget_next        = forget_reg;
        ever_on_next       = ever_on_reg;
        ap_manual_next     = ap_manual_reg;
        busy_valid_next    = busy_valid_reg;
        fast_fail_cnt_next = fast_fail_cnt_reg;
        attempt_idx_next   = attempt_idx_reg;
        round_cnt_next     = round_cnt_reg;
        fail_cnt_next      = fail_cnt_reg;
        tm_online_next     = tm_online_reg;
        tm_lost_next       = tm_lost_reg;
        tm_attempt_next    = tm_attempt_reg;
        tm_wait_next       = tm_wait_reg;
        tm_apreq_next      = tm_apreq_reg;
        tm_busy_next       = tm_busy_reg;
        cur_wait_next      = cur_wait_reg;
        do_start           = 1'b0;
        fast_ok            = 1'b0;
        do_enter           = 1'b0;
        enter_manual       = 1'b0;
        att_inc            = (attempt_idx_reg == 8'hFF) ? 8'hFF : attempt_idx_reg + 8'd1;
        per_round          = (att_per_round_reg == 8'd0) ? 8'd1 : att_per_round_reg;
        fail_lim           = (fast_fail_lim_reg == 8'd0) ? 8'd1 : fast_fail_lim_reg;

        // Portal activity refreshes the busy mark first.
        if (hit_reg || (clients_reg > prev_clients_reg)) begin
            tm_busy_next    = now_reg;
            busy_valid_next = 1'b1;
        end
        keep_manual = ap_manual_reg &&
                      ((clients_reg != 8'd0) || !elapsed(now_reg, tm_busy_next, AP_MANUAL_TIME));

        if (man_reg) begin
            started_next = 1'b1;
            do_enter     = 1'b1;
            enter_manual = 1'b1;
        end else if (newnet_reg) begin
            started_next       = 1'b1;
            ever_on_next       = 1'b0;
            fast_dis_next      = 1'b0;
            fast_fail_cnt_next = '0;
            round_cnt_next     = '0;
            attempt_idx_next   = '0;
            if (!creds_reg) begin
                do_enter = 1'b1;
            end else begin
                mode_next = MODE_CONNECTING;
                do_start  = 1'b1;
                fast_ok   = 1'b1;
            end
        end else if (!started_reg) begin
            if (!(creds_reg && (now_reg < start_delay_reg))) begin
                started_next = 1'b1;
                if (!creds_reg) begin
                    do_enter = 1'b1;
                end else begin
                    do_start = 1'b1;
                    fast_ok  = 1'b1;
                end
            end
        end else if (link_reg) begin
            if (mode_reg != MODE_ONLINE) begin
                mode_next          = MODE_ONLINE;
                tm_online_next     = now_reg;
                attempting_next    = 1'b0;
                fast_dis_next      = 1'b0;
                forget_next        = 1'b0;
                ever_on_next       = 1'b1;
                attempt_idx_next   = '0;
                fast_fail_cnt_next = '0;
                round_cnt_next     = '0;
                fail_cnt_next      = '0;
            end
            if (apup_reg && !keep_manual && ((clients_reg == 8'd0) ||
                elapsed(now_reg, tm_online_next, AP_STOP_GRACE_TIME))) begin
                act_next = ACT_STOP_AP;
            end
        end else if (mode_reg == MODE_ONLINE) begin
            mode_next        = MODE_LOST;
            tm_lost_next     = now_reg;
            attempt_idx_next = '0;
            do_start         = 1'b1;
            fast_ok          = 1'b1;
        end else if (attempting_reg) begin
            if (elapsed(now_reg, tm_attempt_reg, att_timeout_reg)) begin
                attempting_next = 1'b0;
                if (fail_cnt_reg != 16'hFFFF) begin
                    fail_cnt_next = fail_cnt_reg + 16'd1;
                end
                if (att_fast_reg && !fast_dis_reg) begin
                    if (fast_fail_cnt_reg != 8'hFF) begin
                        fast_fail_cnt_next = fast_fail_cnt_reg + 8'd1;
                    end
                    if (fast_fail_cnt_next >= fail_lim) begin
                        fast_dis_next = 1'b1;
                        forget_next   = 1'b1;
                    end
                end
                if (mode_reg != MODE_AP) begin
                    if (att_inc < per_round) begin
                        attempt_idx_next = att_inc;
                        do_start         = 1'b1;
                        fast_ok          = 1'b1;
                    end else begin
                        attempt_idx_next = '0;
                        tm_wait_next     = now_reg;
                        cur_wait_next    = '0;
                        round_cnt_next   = round_cnt_reg + 16'd1;
                        if (!ever_on_reg) begin
                            do_enter = 1'b1;
                        end else if ((mode_reg == MODE_LOST) &&
                                     elapsed(now_reg, tm_lost_reg, lost_fallback_reg)) begin
                            do_enter = 1'b1;
                        end else begin
                            cur_wait_next = round_pause_reg;
                            if (!apup_reg && (restart_every_reg != 8'd0) && mod_zero) begin
                                act_next = ACT_RESTART;
                            end
                        end
                    end
                end
            end
        end else if (forget_reg) begin
            forget_next = 1'b0;
            act_next    = ACT_FORGET;
        end else if (!creds_reg && (mode_reg != MODE_AP)) begin
            do_enter = 1'b1;
        end else if (mode_reg == MODE_AP) begin
            if (!apup_reg && elapsed(now_reg, tm_apreq_reg, AP_RETRY_TIME)) begin
                tm_apreq_next = now_reg;
                act_next      = ACT_START_AP;
            end else if (creds_reg &&
                         !((clients_reg != 8'd0) && busy_valid_next &&
                           !elapsed(now_reg, tm_busy_next, PORTAL_IDLE_TIME)) &&
                         elapsed(now_reg, tm_wait_reg, probe_period_reg)) begin
                do_start = 1'b1;
            end
        end else if ((mode_reg == MODE_LOST) &&
                     elapsed(now_reg, tm_lost_reg, lost_fallback_reg)) begin
            do_enter = 1'b1;
        end else if (elapsed(now_reg, tm_wait_reg, cur_wait_reg)) begin
            do_start = 1'b1;
            fast_ok  = 1'b1;
        end

        // Launch a connect attempt.
        fast_sel = fast_ok && fastp_reg && !fast_dis_next && (attempt_idx_next == 8'd0);
        if (do_start) begin
            att_fast_next   = fast_sel;
            attempting_next = 1'b1;
            tm_attempt_next = now_reg;
            tm_wait_next    = now_reg;
            if (mode_next == MODE_STARTING) begin
                mode_next = MODE_CONNECTING;
            end
            act_next = fast_sel ? ACT_FAST : ACT_SCAN;
        end

        // Fall back to the access point.
        if (do_enter) begin
            mode_next        = MODE_AP;
            attempting_next  = 1'b0;
            attempt_idx_next = '0;
            tm_apreq_next    = now_reg;
            tm_wait_next     = now_reg;
            ap_manual_next   = enter_manual;
            if (enter_manual) begin
                tm_busy_next    = now_reg;
                busy_valid_next = 1'b1;
            end
            act_next = ACT_START_AP;
        end
    end

    // State and result update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg          <= MODE_STARTING;
            started_reg       <= 1'b0;
            attempting_reg    <= 1'b0;
            att_fast_reg      <= 1'b0;
            fast_dis_reg      <= 1'b0;
            forget_reg        <= 1'b0;
            ever_on_reg       <= 1'b0;
            ap_manual_reg     <= 1'b0;
            busy_valid_reg    <= 1'b0;
            prev_clients_reg  <= '0;
            fast_fail_cnt_reg <= '0;
            attempt_idx_reg   <= '0;
            round_cnt_reg     <= '0;
            fail_cnt_reg      <= '0;
            tm_online_reg     <= '0;
            tm_lost_reg       <= '0;
            tm_attempt_reg    <= '0;
            tm_wait_reg       <= '0;
            tm_apreq_reg      <= '0;
            tm_busy_reg       <= '0;
            cur_wait_reg      <= '0;
        end else if (cmd.exec) begin
            mode_reg          <= mode_next;
            started_reg       <= started_next;
            attempting_reg    <= attempting_next;
            att_fast_reg      <= att_fast_next;
            fast_dis_reg      <= fast_dis_next;
            forget_reg        <= forget_next;
            ever_on_reg       <= ever_on_next;
            ap_manual_reg     <= ap_manual_next;
            busy_valid_reg    <= busy_valid_next;
            prev_clients_reg  <= clients_reg;
            fast_fail_cnt_reg <= fast_fail_cnt_next;
            attempt_idx_reg   <= attempt_idx_next;
            round_cnt_reg     <= round_cnt_next;
            fail_cnt_reg      <= fail_cnt_next;
            tm_online_reg     <= tm_online_next;
            tm_lost_reg       <= tm_lost_next;
            tm_attempt_reg    <= tm_attempt_next;
            tm_wait_reg       <= tm_wait_next;
            tm_apreq_reg      <= tm_apreq_next;
            tm_busy_reg       <= tm_busy_next;
            cur_wait_reg      <= cur_wait_next;
        end
    end

    // Result payload register.
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            m_action               <= act_next;
            m_mode                 <= mode_next;
            m_failed_attempt_total <= fail_cnt_next;
        end
    end

endmodule

// File: hdl/wifi_link_recovery_policy_core.sv
// Wi-Fi link recovery policy engine.
// Each input transaction on the s_ channel is one tick: the millisecond time,
// link facts and one-shot requests. For every tick exactly one result
// transaction appears on the m_ channel with the action to take, the policy
// mode after the tick and the count of failed attempts since the last success.
// Each tick passes the capture edge, 16 steps of the bit-serial remainder unit
// that decides the periodic radio restart, the controller seeing the remainder
// finish, and the decision edge that loads the result register. Ticks are
// handled one at a time; the next tick can be accepted in the cycle after the
// result is loaded, so no tick is taken while another is in progress.
// A new tick is accepted while a finished result still waits in the output
// register; if the receiver stalls, the next decision is held until the
// waiting result is taken, and s_ready stays low meanwhile.
// Configuration writes on cfg_we/cfg_addr/cfg_wdata take effect at once and
// are meant for idle periods. Reset (aresetn low, synchronous) restores the
// default register values and clears all policy state; no result is pending.
module wifi_link_recovery_policy_core #(
    parameter logic [31:0] AP_STOP_GRACE_TIME = 32'd60000,
    parameter logic [31:0] AP_RETRY_TIME      = 32'd5000,
    parameter logic [31:0] AP_MANUAL_TIME     = 32'd300000,
    parameter logic [31:0] PORTAL_IDLE_TIME   = 32'd60000
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_time_ms,
    input  logic        s_link_up,
    input  logic        s_has_credentials,
    input  logic        s_has_fast_pair,
    input  logic        s_ap_active,
    input  logic [7:0]  s_ap_client_count,
    input  logic        s_manual_ap_request,
    input  logic        s_new_network_request,
    input  logic        s_portal_hit,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_action,
    output logic [2:0]  m_mode,
    output logic [15:0] m_failed_attempt_total
);
    import wlrp_pkg::*;

    wlrp_cmd_t cmd;
    wlrp_sts_t sts;

    // Transaction sequencing.
    wlrp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Policy state and decision logic.
    wlrp_dpath #(
        .AP_STOP_GRACE_TIME (AP_STOP_GRACE_TIME),
        .AP_RETRY_TIME      (AP_RETRY_TIME),
        .AP_MANUAL_TIME     (AP_MANUAL_TIME),
        .PORTAL_IDLE_TIME   (PORTAL_IDLE_TIME)
    ) u_dpath (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cfg_we                 (cfg_we),
        .cfg_addr               (cfg_addr),
        .cfg_wdata              (cfg_wdata),
        .s_time_ms              (s_time_ms),
        .s_link_up              (s_link_up),
        .s_has_credentials      (s_has_credentials),
        .s_has_fast_pair        (s_has_fast_pair),
        .s_ap_active            (s_ap_active),
        .s_ap_client_count      (s_ap_client_count),
        .s_manual_ap_request    (s_manual_ap_request),
        .s_new_network_request  (s_new_network_request),
        .s_portal_hit           (s_portal_hit),
        .cmd                    (cmd),
        .sts                    (sts),
        .m_action               (m_action),
        .m_mode                 (m_mode),
        .m_failed_attempt_total (m_failed_attempt_total)
    );

endmodule

// File: tb/sv/wifi_link_recovery_policy_core_tb.sv
module wifi_link_recovery_policy_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wlrp_pkg::*;

    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  mode;
        logic [15:0] fails;
    } tick_result_t;

    localparam logic [31:0] AP_STOP_GRACE_TIME_C = 32'd60000;
    localparam logic [31:0] AP_RETRY_TIME_C      = 32'd5000;
    localparam logic [31:0] AP_MANUAL_TIME_C     = 32'd300000;
    localparam logic [31:0] PORTAL_IDLE_TIME_C   = 32'd60000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_time_ms;
    logic        s_link_up;
    logic        s_has_credentials;
    logic        s_has_fast_pair;
    logic        s_ap_active;
    logic [7:0]  s_ap_client_count;
    logic        s_manual_ap_request;
    logic        s_new_network_request;
    logic        s_portal_hit;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_action;
    logic [2:0]  m_mode;
    logic [15:0] m_failed_attempt_total;

    wifi_link_recovery_policy_core dut (.*);

    // Predictor copy of the configuration registers.
    logic [31:0] cf_start, cf_timeout, cf_probe, cf_lost, cf_pause;
    logic [7:0]  cf_per_round, cf_fast_lim, cf_restart;

    // Predictor copy of the policy state.
    logic [2:0]  pm_mode;
    logic        pf_started, pf_attempting, pf_att_fast, pf_fast_dis;
    logic        pf_forget, pf_ever_on, pf_ap_manual, pf_busy_valid;
    logic [7:0]  p_prev_clients, p_fast_fails, p_att_idx;
    logic [15:0] p_rounds, p_fails;
    logic [31:0] t_online, t_lost, t_attempt, t_wait, t_ap_req, t_busy, p_cur_wait;

    tick_result_t expected_results[$];
    int          mismatches;
    bit          idle_en;
    logic [2:0]  last_action;

    // Stimulus world model.
    logic [31:0] w_time;
    logic        w_link, w_ap;
    logic [7:0]  w_clients;
    int          step_max;

    always #6 aclk = ~aclk;

    function automatic bit passed(logic [31:0] now, logic [31:0] since, logic [31:0] per);
        logic [31:0] d;
        d = now - since;
        return d >= per;
    endfunction

    function automatic logic [2:0] begin_attempt(logic [31:0] now, bit fast_ok, bit fp);
        bit fast;
        fast = fast_ok && fp && !pf_fast_dis && p_att_idx == 8'd0;
        pf_att_fast = fast;
        pf_attempting = 1'b1;
        t_attempt = now;
        t_wait = now;
        if (pm_mode == MODE_STARTING) pm_mode = MODE_CONNECTING;
        return fast ? ACT_FAST : ACT_SCAN;
    endfunction

    function automatic logic [2:0] raise_ap(logic [31:0] now, bit manual);
        pm_mode = MODE_AP;
        pf_attempting = 1'b0;
        p_att_idx = 8'd0;
        t_ap_req = now;
        t_wait = now;
        pf_ap_manual = manual;
        if (manual) begin
            t_busy = now;
            pf_busy_valid = 1'b1;
        end
        return ACT_START_AP;
    endfunction

    function automatic logic [2:0] attempt_failed(logic [31:0] now, bit fp, bit ap);
        logic [7:0] lim, per;
        pf_attempting = 1'b0;
        if (p_fails != 16'hFFFF) p_fails++;
        if (pf_att_fast && !pf_fast_dis) begin
            if (p_fast_fails != 8'hFF) p_fast_fails++;
            lim = (cf_fast_lim == 8'd0) ? 8'd1 : cf_fast_lim;
            if (p_fast_fails >= lim) begin
                pf_fast_dis = 1'b1;
                pf_forget = 1'b1;
            end
        end
        if (pm_mode == MODE_AP) return ACT_NONE;
        if (p_att_idx != 8'hFF) p_att_idx++;
        per = (cf_per_round == 8'd0) ? 8'd1 : cf_per_round;
        if (p_att_idx < per) return begin_attempt(now, 1'b1, fp);
        // The round is over.
        p_att_idx = 8'd0;
        t_wait = now;
        p_cur_wait = 32'd0;
        p_rounds++;
        if (!pf_ever_on) return raise_ap(now, 1'b0);
        if (pm_mode == MODE_LOST && passed(now, t_lost, cf_lost)) return raise_ap(now, 1'b0);
        p_cur_wait = cf_pause;
        if (!ap && cf_restart != 8'd0 && (p_rounds % cf_restart) == 0) return ACT_RESTART;
        return ACT_NONE;
    endfunction

    function automatic logic [2:0] policy_decide(logic [31:0] now, bit link, bit creds, bit fp,
                                                 bit ap, logic [7:0] cl, bit man, bit nn, bit hit);
        bit keep_manual, busy;
        if (hit || cl > p_prev_clients) begin
            t_busy = now;
            pf_busy_valid = 1'b1;
        end
        p_prev_clients = cl;
        if (man) begin
            pf_started = 1'b1;
            return raise_ap(now, 1'b1);
        end
        if (nn) begin
            pf_started = 1'b1;
            pf_ever_on = 1'b0;
            pf_fast_dis = 1'b0;
            p_fast_fails = 8'd0;
            p_rounds = 16'd0;
            p_att_idx = 8'd0;
            if (!creds) return raise_ap(now, 1'b0);
            pm_mode = MODE_CONNECTING;
            return begin_attempt(now, 1'b1, fp);
        end
        if (!pf_started) begin
            if (creds && now < cf_start) return ACT_NONE;
            pf_started = 1'b1;
            if (!creds) return raise_ap(now, 1'b0);
            return begin_attempt(now, 1'b1, fp);
        end
        if (link) begin
            if (pm_mode != MODE_ONLINE) begin
                pm_mode = MODE_ONLINE;
                t_online = now;
                pf_attempting = 1'b0;
                pf_fast_dis = 1'b0;
                pf_forget = 1'b0;
                pf_ever_on = 1'b1;
                p_att_idx = 8'd0;
                p_fast_fails = 8'd0;
                p_rounds = 16'd0;
                p_fails = 16'd0;
            end
            keep_manual = pf_ap_manual && (cl != 0 || !passed(now, t_busy, AP_MANUAL_TIME_C));
            if (ap && !keep_manual && (cl == 0 || passed(now, t_online, AP_STOP_GRACE_TIME_C)))
                return ACT_STOP_AP;
            return ACT_NONE;
        end
        if (pm_mode == MODE_ONLINE) begin
            pm_mode = MODE_LOST;
            t_lost = now;
            p_att_idx = 8'd0;
            return begin_attempt(now, 1'b1, fp);
        end
        if (pf_attempting) begin
            if (!passed(now, t_attempt, cf_timeout)) return ACT_NONE;
            return attempt_failed(now, fp, ap);
        end
        if (pf_forget) begin
            pf_forget = 1'b0;
            return ACT_FORGET;
        end
        if (!creds && pm_mode != MODE_AP) return raise_ap(now, 1'b0);
        if (pm_mode == MODE_AP) begin
            if (!ap && passed(now, t_ap_req, AP_RETRY_TIME_C)) begin
                t_ap_req = now;
                return ACT_START_AP;
            end
            busy = cl != 0 && pf_busy_valid && !passed(now, t_busy, PORTAL_IDLE_TIME_C);
            if (!creds || busy) return ACT_NONE;
            if (!passed(now, t_wait, cf_probe)) return ACT_NONE;
            return begin_attempt(now, 1'b0, fp);
        end
        if (pm_mode == MODE_LOST && passed(now, t_lost, cf_lost)) return raise_ap(now, 1'b0);
        if (!passed(now, t_wait, p_cur_wait)) return ACT_NONE;
        return begin_attempt(now, 1'b1, fp);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Write one configuration register and mirror it in the predictor.
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_START_DELAY:   cf_start = val;
            REG_ATT_TIMEOUT:   cf_timeout = val;
            REG_PROBE_PERIOD:  cf_probe = val;
            REG_LOST_FALLBACK: cf_lost = val;
            REG_ROUND_PAUSE:   cf_pause = val;
            REG_ATT_PER_ROUND: cf_per_round = val[7:0];
            REG_FAST_FAIL_LIM: cf_fast_lim = val[7:0];
            REG_RESTART_EVERY: cf_restart = val[7:0];
            default: ;
        endcase
    endtask

    // Write every register back to back, then release the write enable.
    task automatic write_all(logic [31:0] st, logic [31:0] to, logic [31:0] pr, logic [31:0] lo,
                             logic [31:0] pa, logic [7:0] apr, logic [7:0] ffl, logic [7:0] rs);
        write_reg(REG_START_DELAY, st);
        write_reg(REG_ATT_TIMEOUT, to);
        write_reg(REG_PROBE_PERIOD, pr);
        write_reg(REG_LOST_FALLBACK, lo);
        write_reg(REG_ROUND_PAUSE, pa);
        write_reg(REG_ATT_PER_ROUND, {24'd0, apr} | (32'($urandom) & 32'hFFFFFF00));
        write_reg(REG_FAST_FAIL_LIM, {24'd0, ffl});
        write_reg(REG_RESTART_EVERY, {24'd0, rs});
        cfg_we <= 1'b0;
    endtask

    // Wait until every expected result has come back.
    task automatic drain;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (25) @(posedge aclk);
    endtask

    // Send one tick; the valid stays high across back-to-back transactions.
    task automatic send_tick(logic [31:0] t, bit link, bit creds, bit fp, bit ap,
                             logic [7:0] cl, bit man, bit nn, bit hit);
        tick_result_t r;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_time_ms <= t;
        s_link_up <= link;
        s_has_credentials <= creds;
        s_has_fast_pair <= fp;
        s_ap_active <= ap;
        s_ap_client_count <= cl;
        s_manual_ap_request <= man;
        s_new_network_request <= nn;
        s_portal_hit <= hit;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        r.action = policy_decide(t, link, creds, fp, ap, cl, man, nn, hit);
        r.mode = pm_mode;
        r.fails = p_fails;
        last_action = r.action;
        expected_results.push_back(r);
    endtask

    task automatic end_burst;
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // One tick of a plausible world: time moves on and the AP follows the actions.
    task automatic random_tick;
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) w_time = w_time;
        else if (r < 90) w_time = w_time + $urandom_range(0, step_max);
        else if (r < 96) w_time = w_time + $urandom;
        else w_time = 32'hFFFFFFFF - $urandom_range(0, step_max);
        if ($urandom_range(0, 99) < 10) w_link = ~w_link;
        if (last_action == ACT_START_AP) w_ap = 1'b1;
        if (last_action == ACT_STOP_AP) w_ap = 1'b0;
        if ($urandom_range(0, 99) < 6) w_ap = ~w_ap;
        r = $urandom_range(0, 99);
        if (r < 60) w_clients = 8'd0;
        else if (r < 85) w_clients = w_clients + 8'd1;
        else w_clients = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 19) == 0)
            send_tick($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        else
            send_tick(w_time, w_link, $urandom_range(0, 99) < 93, $urandom_range(0, 99) < 70,
                      w_ap, w_clients, $urandom_range(0, 99) < 2, $urandom_range(0, 99) < 3,
                      $urandom_range(0, 99) < 5);
    endtask

    task automatic random_run(int n);
        repeat (n) random_tick();
        end_burst();
        drain();
    endtask

    // Directed ticks with the default registers: start delay, fallback, requests, extremes.
    task automatic test_directed;
        send_tick(32'd0, 1'b0, 1'b1, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_tick(32'd2999, 1'b0, 1'b1, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0, 1'b1);
        send_tick(32'd3000, 1'b0, 1'b1, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_tick(32'd18000, 1'b0, 1'b1, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_tick(32'd33000, 1'b0, 1'b1, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_tick(32'd33001, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_tick(32'd40000, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_tick(32'd93001, 1'b0, 1'b1, 1'b1, 1'b1, 8'd0, 1'b0, 1'b0, 1'b0);
        send_tick(32'd93500, 1'b1, 1'b1, 1'b1, 1'b1, 8'd3, 1'b0, 1'b0, 1'b0);
        send_tick(32'd160000, 1'b1, 1'b1, 1'b1, 1'b1, 8'd255, 1'b0, 1'b0, 1'b1);
        send_tick(32'd160001, 1'b1, 1'b1, 1'b1, 1'b1, 8'd0, 1'b0, 1'b0, 1'b0);
        send_tick(32'd170000, 1'b0, 1'b1, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_tick(32'd185000, 1'b0, 1'b1, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_tick(32'd300000, 1'b0, 1'b1, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_tick(32'd300100, 1'b0, 1'b1, 1'b1, 1'b0, 8'd5, 1'b1, 1'b1, 1'b1);
        send_tick(32'd300200, 1'b1, 1'b1, 1'b1, 1'b1, 8'd4, 1'b0, 1'b0, 1'b0);
        send_tick(32'd700000, 1'b1, 1'b1, 1'b1, 1'b1, 8'd0, 1'b0, 1'b0, 1'b0);
        send_tick(32'd700001, 1'b0, 1'b0, 1'b0, 1'b1, 8'd0, 1'b0, 1'b1, 1'b0);
        send_tick(32'd710000, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_tick(32'd720000, 1'b0, 1'b1, 1'b1, 1'b0, 8'd0, 1'b0, 1'b1, 1'b0);
        send_tick(32'hFFFFFFFF, 1'b0, 1'b1, 1'b1, 1'b0, 8'd255, 1'b0, 1'b0, 1'b0);
        send_tick(32'h00001000, 1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0, 1'b1);
        end_burst();
        drain();
    endtask

    // Short periods so rounds, fallback, forgetting and restarts happen often.
    task automatic test_short_periods;
        write_all(32'd50, 32'd40, 32'd100, 32'd200, 32'd60, 8'd3, 8'd2, 8'd2);
        step_max = 60;
        random_run(450);
    endtask

    // Zero periods and degenerate counts.
    task automatic test_zero_limits;
        write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 8'd0, 8'd0, 8'd1);
        step_max = 20;
        random_run(250);
        write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 8'd1, 8'd1, 8'd0);
        random_run(150);
    endtask

    // All registers at their maximum.
    task automatic test_max_limits;
        write_all(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                  8'hFF, 8'hFF, 8'hFF);
        step_max = 100000;
        random_run(200);
    endtask

    // Random mid-range registers, with no idling on either side.
    task automatic test_random_settings;
        write_all($urandom_range(0, 500), $urandom_range(1, 300), $urandom_range(1, 600),
                  $urandom_range(0, 900), $urandom_range(0, 400), 8'($urandom_range(1, 4)),
                  8'($urandom_range(1, 4)), 8'($urandom_range(0, 5)));
        step_max = 150;
        idle_en = 1'b0;
        random_run(520);
    endtask

    // Result checker.
    always @(posedge aclk) begin
        tick_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("MISMATCH unexpected result transaction at %0t", $realtime);
                mismatches++;
            end else begin
                e = expected_results.pop_front();
                if (m_action !== e.action) report_mismatch("action", m_action, e.action);
                if (m_mode !== e.mode) report_mismatch("mode", m_mode, e.mode);
                if (m_failed_attempt_total !== e.fails)
                    report_mismatch("failed_attempt_total", m_failed_attempt_total, e.fails);
            end
        end
    end

    // Receiver stalls in bursts.
    initial begin
        m_ready <= 1'b1;
        forever begin
            repeat ($urandom_range(1, 20)) @(posedge aclk);
            if (idle_en && $urandom_range(0, 1) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        #20ms;
        $display("wifi_link_recovery_policy_core test failed");
        $finish;
    end

    initial begin
        aclk = 1'b0;
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_addr <= REG_START_DELAY;
        cfg_wdata <= 32'd0;
        s_valid <= 1'b0;
        s_time_ms <= 32'd0;
        s_link_up <= 1'b0;
        s_has_credentials <= 1'b0;
        s_has_fast_pair <= 1'b0;
        s_ap_active <= 1'b0;
        s_ap_client_count <= 8'd0;
        s_manual_ap_request <= 1'b0;
        s_new_network_request <= 1'b0;
        s_portal_hit <= 1'b0;
        mismatches = 0;
        idle_en = 1'b1;
        last_action = ACT_NONE;
        w_time = 32'd0;
        w_link = 1'b0;
        w_ap = 1'b0;
        w_clients = 8'd0;
        step_max = 60;
        cf_start = 32'd3000;
        cf_timeout = 32'd15000;
        cf_probe = 32'd60000;
        cf_lost = 32'd120000;
        cf_pause = 32'd30000;
        cf_per_round = 8'd2;
        cf_fast_lim = 8'd3;
        cf_restart = 8'd3;
        pm_mode = MODE_STARTING;
        {pf_started, pf_attempting, pf_att_fast, pf_fast_dis} = 4'b0;
        {pf_forget, pf_ever_on, pf_ap_manual, pf_busy_valid} = 4'b0;
        p_prev_clients = 8'd0;
        p_fast_fails = 8'd0;
        p_att_idx = 8'd0;
        p_rounds = 16'd0;
        p_fails = 16'd0;
        {t_online, t_lost, t_attempt, t_wait, t_ap_req, t_busy, p_cur_wait} = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_short_periods();
        test_zero_limits();
        test_max_limits();
        test_random_settings();

        if (mismatches == 0)
            $display("wifi_link_recovery_policy_core test passed");
        else
            $display("wifi_link_recovery_policy_core test failed");
        $finish;
    end

endmodule

// File: filelist.f
hdl/wlrp_pkg.sv
hdl/wlrp_ctrl.sv
hdl/wlrp_dpath.sv
hdl/wifi_link_recovery_policy_core.sv
tb/sv/wifi_link_recovery_policy_core_tb.sv
